### hdl/tshr_pkg.sv
// ----------------------------------------------------------------------------
// tshr_pkg
// shared constants, field layout, controller states and the command and
// status bundles between the controller and the datapath
// ----------------------------------------------------------------------------
package tshr_pkg;

	localparam int unsigned HISTORY_DEPTH_DEF = 60;
	localparam int unsigned CHANNELS_DEF      = 4;

	localparam int unsigned SAMPLE_W = 16;
	localparam int unsigned TS_W     = 32;
	localparam int unsigned CHAN_W   = 2;
	localparam int unsigned SLOT_W   = 16;

	localparam logic [SLOT_W-1:0] SLOT_LEN_RST = 16'd200;

	// input beat layout, lowest bits first
	localparam int unsigned CH_LSB    = 0;
	localparam int unsigned VOLT_LSB  = CH_LSB + CHAN_W;
	localparam int unsigned CURR_LSB  = VOLT_LSB + SAMPLE_W;
	localparam int unsigned TS_LSB    = CURR_LSB + SAMPLE_W;
	localparam int unsigned IN_DATA_W = 72;

	localparam int unsigned OUT_DATA_W = 2 * SAMPLE_W;

	localparam logic FUNC_RECORD = 1'b0;
	localparam logic FUNC_READ   = 1'b1;

	typedef enum logic [3:0] {
		S_IDLE,
		S_LOAD,
		S_DECIDE,
		S_DIV,
		S_DIVDONE,
		S_FILL,
		S_APPEND,
		S_OVERWRITE,
		S_COMMIT,
		S_RD_ISSUE,
		S_RD_LOAD
	} ctl_state_t;

	typedef struct packed {
		logic load_item;
		logic load_chan;
		logic set_lt;
		logic div_init;
		logic div_step;
		logic fill_init;
		logic fill_write;
		logic append_write;
		logic newest_write;
		logic commit;
		logic rd_init;
		logic rd_issue;
		logic rd_load;
	} cmd_t;

	typedef struct packed {
		logic is_read;
		logic chan_ok;
		logic do_append;
		logic not_newer;
		logic div_last;
		logic quo_zero;
		logic fill_zero;
		logic out_free;
		logic rd_last;
	} sts_t;

endpackage

### hdl/tshr_ctrl.sv
// ----------------------------------------------------------------------------
// tshr_ctrl
// sequencer: takes an item, decides how a sample lands in the ring, runs the
// slot divider and gap fill, or walks the ring for a read-out
// ----------------------------------------------------------------------------
module tshr_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  tshr_pkg::sts_t  sts,
	output tshr_pkg::cmd_t  cmd
);
	import tshr_pkg::*;

	ctl_state_t state_q;
	ctl_state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_nxt = S_LOAD;
				end
			end
			S_LOAD: begin
				state_nxt = S_DECIDE;
			end
			S_DECIDE: begin
				if (sts.is_read) begin
					state_nxt = S_RD_ISSUE;
				end else if (!sts.chan_ok) begin
					state_nxt = S_IDLE;
				end else if (sts.do_append) begin
					state_nxt = S_APPEND;
				end else if (sts.not_newer) begin
					state_nxt = S_OVERWRITE;
				end else begin
					state_nxt = S_DIV;
				end
			end
			S_DIV: begin
				if (sts.div_last) begin
					state_nxt = S_DIVDONE;
				end
			end
			S_DIVDONE: begin
				state_nxt = sts.quo_zero ? S_OVERWRITE : S_FILL;
			end
			S_FILL: begin
				if (sts.fill_zero) begin
					state_nxt = S_APPEND;
				end
			end
			S_APPEND: begin
				state_nxt = S_COMMIT;
			end
			S_OVERWRITE: begin
				state_nxt = S_COMMIT;
			end
			S_COMMIT: begin
				state_nxt = S_IDLE;
			end
			S_RD_ISSUE: begin
				state_nxt = S_RD_LOAD;
			end
			S_RD_LOAD: begin
				if (sts.out_free) begin
					state_nxt = sts.rd_last ? S_IDLE : S_RD_ISSUE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready      = 1'b1;
				cmd.load_item = in_valid;
			end
			S_LOAD: begin
				cmd.load_chan = 1'b1;
			end
			S_DECIDE: begin
				if (sts.is_read) begin
					cmd.rd_init = 1'b1;
				end else if (sts.chan_ok) begin
					if (sts.do_append) begin
						cmd.set_lt = 1'b1;
					end else if (!sts.not_newer) begin
						cmd.div_init = 1'b1;
					end
				end
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
			end
			S_DIVDONE: begin
				cmd.set_lt    = 1'b1;
				cmd.fill_init = 1'b1;
			end
			S_FILL: begin
				cmd.fill_write = !sts.fill_zero;
			end
			S_APPEND: begin
				cmd.append_write = 1'b1;
			end
			S_OVERWRITE: begin
				cmd.newest_write = 1'b1;
			end
			S_COMMIT: begin
				cmd.commit = 1'b1;
			end
			S_RD_ISSUE: begin
				cmd.rd_issue = 1'b1;
			end
			S_RD_LOAD: begin
				cmd.rd_load = sts.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

### hdl/tshr_dpath.sv
// ----------------------------------------------------------------------------
// tshr_dpath
// point memory, per-channel ring pointers, restoring slot divider and the
// registered read-out stage
// ----------------------------------------------------------------------------
module tshr_dpath #(
	parameter int unsigned HISTORY_DEPTH = tshr_pkg::HISTORY_DEPTH_DEF,
	parameter int unsigned CHANNELS      = tshr_pkg::CHANNELS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  tshr_pkg::cmd_t                      cmd,
	output tshr_pkg::sts_t                      sts,
	input  logic [tshr_pkg::IN_DATA_W-1:0]      in_data,
	input  logic                                in_func,
	input  logic                                cfg_we,
	input  logic [tshr_pkg::SLOT_W-1:0]         cfg_data,
	input  logic                                out_ready,
	output logic                                out_valid,
	output logic [tshr_pkg::OUT_DATA_W-1:0]     out_data,
	output logic                                out_flag,
	output logic                                out_last
);
	import tshr_pkg::*;

	localparam int unsigned PW        = $clog2(HISTORY_DEPTH);
	localparam int unsigned CW        = $clog2(HISTORY_DEPTH + 1);
	localparam int unsigned CHW       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int unsigned AW        = CHW + PW;
	localparam int unsigned MEM_DEPTH = CHANNELS << PW;
	localparam int unsigned DIV_STEPS = TS_W;
	localparam int unsigned DCW       = $clog2(DIV_STEPS);

	localparam logic [PW-1:0] POS_LAST = PW'(HISTORY_DEPTH - 1);

	// item registers
	logic                 func_q;
	logic [CHAN_W-1:0]    chan_q;
	logic [SAMPLE_W-1:0]  volt_q;
	logic [SAMPLE_W-1:0]  curr_q;
	logic [TS_W-1:0]      ts_q;

	logic [SLOT_W-1:0]    slot_len_q;
	logic [SLOT_W-1:0]    len_eff;

	logic [CHW+CHAN_W-1:0] ch_wide;
	logic [CHW-1:0]        ch_idx;
	logic                  ch_ok;

	logic [PW-1:0]   wp_arr_q [CHANNELS];
	logic [CW-1:0]   fc_arr_q [CHANNELS];
	logic [TS_W-1:0] lt_arr_q [CHANNELS];

	logic [PW-1:0]   wp_q;
	logic [CW-1:0]   fc_q;
	logic [TS_W-1:0] lt_q;
	logic [PW-1:0]   newest;
	logic [PW-1:0]   wp_next;
	logic [CW-1:0]   fc_next;

	logic [SLOT_W-1:0] rem_q;
	logic [TS_W-1:0]   dvd_q;
	logic [DCW-1:0]    div_cnt_q;
	logic [SLOT_W:0]   rem_shift;
	logic [SLOT_W:0]   rem_diff;
	logic              rem_ge;
	logic              quo_big;
	logic [PW-1:0]     copies_q;

	logic [OUT_DATA_W-1:0] mem [MEM_DEPTH];
	logic [OUT_DATA_W-1:0] rd_q;
	logic                  mem_we;
	logic                  mem_re;
	logic [AW-1:0]         mem_waddr;
	logic [AW-1:0]         mem_raddr;
	logic [OUT_DATA_W-1:0] mem_wdata;

	logic [PW-1:0] rp_q;
	logic [PW-1:0] ri_q;
	logic [CW-1:0] cnt_q;
	logic          pos_valid;

	logic                  out_valid_q;
	logic [OUT_DATA_W-1:0] out_data_q;
	logic                  out_flag_q;
	logic                  out_last_q;

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			func_q <= in_func;
			chan_q <= in_data[CH_LSB +: CHAN_W];
			volt_q <= in_data[VOLT_LSB +: SAMPLE_W];
			curr_q <= in_data[CURR_LSB +: SAMPLE_W];
			ts_q   <= in_data[TS_LSB +: TS_W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_len_q <= SLOT_LEN_RST;
		end else if (cfg_we) begin
			slot_len_q <= cfg_data;
		end
	end

	// zero slot length counts as one millisecond
	assign len_eff = (slot_len_q == '0) ? SLOT_W'(1) : slot_len_q;

	assign ch_wide = {{CHW{1'b0}}, chan_q};
	assign ch_idx  = ch_wide[CHW-1:0];
	assign ch_ok   = ch_wide < (CHW + CHAN_W)'(CHANNELS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				wp_arr_q[i] <= '0;
				fc_arr_q[i] <= '0;
				lt_arr_q[i] <= '0;
			end
		end else if (cmd.commit && ch_ok) begin
			wp_arr_q[ch_idx] <= wp_q;
			fc_arr_q[ch_idx] <= fc_q;
			lt_arr_q[ch_idx] <= lt_q;
		end
	end

	assign newest  = (wp_q == '0) ? POS_LAST : wp_q - 1'b1;
	assign wp_next = (wp_q == POS_LAST) ? '0 : wp_q + 1'b1;
	assign fc_next = (fc_q < CW'(HISTORY_DEPTH)) ? fc_q + 1'b1 : fc_q;

	always_ff @(posedge clk) begin
		if (cmd.load_chan) begin
			if (ch_ok) begin
				wp_q <= wp_arr_q[ch_idx];
				fc_q <= fc_arr_q[ch_idx];
				lt_q <= lt_arr_q[ch_idx];
			end else begin
				wp_q <= '0;
				fc_q <= '0;
				lt_q <= '0;
			end
		end else begin
			if (cmd.fill_write || cmd.append_write) begin
				wp_q <= wp_next;
				fc_q <= fc_next;
			end
			if (cmd.set_lt) begin
				lt_q <= ts_q;
			end
		end
	end

	// restoring divide, one quotient bit per beat of the step command
	assign rem_shift = {rem_q, dvd_q[TS_W-1]};
	assign rem_diff  = rem_shift - {1'b0, len_eff};
	assign rem_ge    = rem_shift >= {1'b0, len_eff};
	assign quo_big   = dvd_q >= TS_W'(HISTORY_DEPTH);

	always_ff @(posedge clk) begin
		if (cmd.div_init) begin
			dvd_q     <= ts_q - lt_q;
			rem_q     <= '0;
			div_cnt_q <= '0;
		end else if (cmd.div_step) begin
			dvd_q     <= {dvd_q[TS_W-2:0], rem_ge};
			rem_q     <= rem_ge ? rem_diff[SLOT_W-1:0] : rem_shift[SLOT_W-1:0];
			div_cnt_q <= div_cnt_q + 1'b1;
		end
	end

	// copies of the held newest point come before the new point
	always_ff @(posedge clk) begin
		if (cmd.fill_init) begin
			copies_q <= quo_big ? POS_LAST : dvd_q[PW-1:0] - 1'b1;
		end else if (cmd.fill_write) begin
			copies_q <= copies_q - 1'b1;
		end
	end

	assign mem_we    = cmd.fill_write || cmd.append_write || cmd.newest_write;
	assign mem_waddr = cmd.newest_write ? {ch_idx, newest} : {ch_idx, wp_q};
	assign mem_wdata = cmd.fill_write ? rd_q : {curr_q, volt_q};
	assign mem_re    = (cmd.div_init || cmd.rd_issue) && ch_ok;
	assign mem_raddr = cmd.rd_issue ? {ch_idx, rp_q} : {ch_idx, newest};

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rd_q <= mem[mem_raddr];
		end
	end

	// read-out walk, oldest first
	always_ff @(posedge clk) begin
		if (cmd.rd_init) begin
			cnt_q <= ch_ok ? fc_q : '0;
			rp_q  <= (ch_ok && fc_q >= CW'(HISTORY_DEPTH)) ? wp_q : '0;
			ri_q  <= '0;
		end else if (cmd.rd_load) begin
			rp_q <= (rp_q == POS_LAST) ? '0 : rp_q + 1'b1;
			ri_q <= ri_q + 1'b1;
		end
	end

	assign pos_valid = CW'(ri_q) < cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.rd_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_load) begin
			out_data_q <= pos_valid ? rd_q : '0;
			out_flag_q <= pos_valid;
			out_last_q <= ri_q == POS_LAST;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;
	assign out_flag  = out_flag_q;
	assign out_last  = out_last_q;

	assign sts.is_read   = func_q == FUNC_READ;
	assign sts.chan_ok   = ch_ok;
	assign sts.do_append = (fc_q == '0) || (ts_q == '0) || (lt_q == '0);
	assign sts.not_newer = ts_q <= lt_q;
	assign sts.div_last  = div_cnt_q == DCW'(DIV_STEPS - 1);
	assign sts.quo_zero  = dvd_q == '0;
	assign sts.fill_zero = copies_q == '0;
	assign sts.out_free  = !out_valid_q || out_ready;
	assign sts.rd_last   = ri_q == POS_LAST;

endmodule

### hdl/time_slotted_history_ring_top.sv
// ----------------------------------------------------------------------------
// time_slotted_history_ring_top
// per-channel ring of voltage/current points, one point per time slot
// ----------------------------------------------------------------------------
// A record beat (tuser 0) places one sample into its channel's ring, as an
// append or as an overwrite of the newest point. A newer sample outside
// those cases runs a 32-step restoring divide of the time gap by the slot
// length. If that gap stays inside one slot it ends as an overwrite.
// Otherwise one gap copy is written per cycle, up to HISTORY_DEPTH - 1
// copies, and the sample is appended after them.
// A read beat (tuser 1) returns HISTORY_DEPTH beats, oldest first. Each beat
// takes one memory read and then one load of the output register, and that
// load waits while the output still holds a beat. The next item can be
// accepted while the final beat is still waiting on the output. Empty
// positions come out as zero with tuser low. The point memory needs no
// clearing after reset.
// ----------------------------------------------------------------------------
module time_slotted_history_ring_top #(
	parameter int unsigned HISTORY_DEPTH = tshr_pkg::HISTORY_DEPTH_DEF,
	parameter int unsigned CHANNELS      = tshr_pkg::CHANNELS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// channel, volt_sample, curr_sample, timestamp, zero pad
	input  logic [tshr_pkg::IN_DATA_W-1:0]    s_axis_tdata,
	// func
	input  logic                              s_axis_tuser,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// volt_point, curr_point
	output logic [tshr_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
	// point_valid
	output logic                              m_axis_tuser,
	output logic                              m_axis_tlast,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [tshr_pkg::SLOT_W-1:0]       cfg_data
);
	import tshr_pkg::*;

	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;

	tshr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	tshr_dpath #(
		.HISTORY_DEPTH (HISTORY_DEPTH),
		.CHANNELS      (CHANNELS)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_data   (s_axis_tdata),
		.in_func   (s_axis_tuser),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_data  (cfg_data),
		.out_ready (m_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_data  (m_axis_tdata),
		.out_flag  (m_axis_tuser),
		.out_last  (m_axis_tlast)
	);

	// empty positions read as zero
	a_empty_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
		else $error("empty position carries data");

	// no ring write while waiting for an item
	a_idle_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready |-> !(cmd.fill_write || cmd.append_write || cmd.newest_write))
		else $error("ring written while idle");

	// a new beat is never loaded over one still waiting
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_load |-> !m_axis_tvalid || m_axis_tready)
		else $error("output beat overwritten");

	// an accepted item keeps the block busy for at least the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("ready right after accept");

endmodule

### bench/tb_time_slotted_history_ring_top.sv
// ----------------------------------------------------------------------------
// tb_time_slotted_history_ring_top
// Self-checking bench for the slotted voltage/current history ring. A queue
// of record and read beats feeds a clocked driver. Each accepted beat runs
// through a local ring predictor, and a clocked monitor compares every output
// beat with the oldest predicted point. The slot length is changed between
// phases, but only once the block has drained.
// ----------------------------------------------------------------------------
module tb_time_slotted_history_ring_top;
	timeunit 1ns;
	timeprecision 1ps;

	import tshr_pkg::*;

	localparam int unsigned DEPTH = HISTORY_DEPTH_DEF;
	localparam int unsigned NCH = CHANNELS_DEF;
	localparam int SETTLE_CYCLES = 200;
	localparam int LONG_HOLD = 600;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int MAX_PRINTS = 200;

	typedef struct {
		logic func;
		logic [CHAN_W-1:0] ch;
		logic [SAMPLE_W-1:0] volt;
		logic [SAMPLE_W-1:0] curr;
		logic [TS_W-1:0] ts;
	} ring_req_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] volt;
		logic [SAMPLE_W-1:0] curr;
		logic valid;
		logic is_last;
	} ring_point_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [IN_DATA_W-1:0] s_axis_tdata = '0;
	logic s_axis_tuser = 1'b0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic m_axis_tuser;
	logic m_axis_tlast;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [SLOT_W-1:0] cfg_data = '0;

	// predictor state
	logic [SAMPLE_W-1:0] volt_ring [NCH][DEPTH];
	logic [SAMPLE_W-1:0] curr_ring [NCH][DEPTH];
	int unsigned ring_wr_pos [NCH];
	int unsigned ring_fill [NCH];
	logic [TS_W-1:0] ring_last_ts [NCH];
	logic [SLOT_W-1:0] slot_len_ms = SLOT_LEN_RST;

	ring_req_t pending_reqs [$];
	ring_point_t expected_points [$];
	ring_req_t cur_req;
	logic [IN_DATA_W-1:0] beat_bits;
	logic [TS_W-1:0] stim_ts [NCH];
	int tx_gap = 0;
	int rx_hold = 0;
	bit no_idle = 1'b0;
	bit long_hold_req = 1'b0;
	int mismatch_count = 0;
	int beat_no = 0;
	int cycle_count = 0;

	time_slotted_history_ring_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	task automatic report_mismatch(input string what);
		if (mismatch_count < MAX_PRINTS)
			$display("%0t mismatch: %s", $realtime, what);
		mismatch_count++;
	endtask

	function automatic int draw_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		else if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic void ring_push(input int unsigned ch, input logic [SAMPLE_W-1:0] v,
			input logic [SAMPLE_W-1:0] c);
		volt_ring[ch][ring_wr_pos[ch]] = v;
		curr_ring[ch][ring_wr_pos[ch]] = c;
		ring_wr_pos[ch] = (ring_wr_pos[ch] + 1) % DEPTH;
		if (ring_fill[ch] < DEPTH)
			ring_fill[ch]++;
	endfunction

	function automatic void ring_overwrite_newest(input int unsigned ch,
			input logic [SAMPLE_W-1:0] v, input logic [SAMPLE_W-1:0] c);
		int unsigned p;
		p = (ring_wr_pos[ch] + DEPTH - 1) % DEPTH;
		if (ring_fill[ch] == 0) begin
			ring_push(ch, v, c);
		end else begin
			volt_ring[ch][p] = v;
			curr_ring[ch][p] = c;
		end
	endfunction

	// updates the ring copy for one accepted beat and queues the points it returns
	function automatic void predict_item(input ring_req_t req);
		int unsigned ch;
		int unsigned len;
		int unsigned slots;
		int unsigned p;
		int unsigned start;
		logic [SAMPLE_W-1:0] hold_v;
		logic [SAMPLE_W-1:0] hold_c;
		ring_point_t pt;
		ch = 32'(req.ch);
		if (ch >= NCH) begin
			if (req.func == FUNC_READ) begin
				for (int i = 0; i < DEPTH; i++) begin
					pt = '0;
					pt.is_last = (i == DEPTH - 1);
					expected_points.push_back(pt);
				end
			end
			return;
		end
		if (req.func == FUNC_READ) begin
			start = (ring_fill[ch] >= DEPTH) ? ring_wr_pos[ch] : 0;
			for (int unsigned i = 0; i < DEPTH; i++) begin
				pt = '0;
				if (i < ring_fill[ch]) begin
					p = (start + i) % DEPTH;
					pt.volt = volt_ring[ch][p];
					pt.curr = curr_ring[ch][p];
					pt.valid = 1'b1;
				end
				pt.is_last = (i == DEPTH - 1);
				expected_points.push_back(pt);
			end
		end else if (ring_fill[ch] == 0 || req.ts == 0 || ring_last_ts[ch] == 0) begin
			ring_push(ch, req.volt, req.curr);
			ring_last_ts[ch] = req.ts;
		end else if (req.ts <= ring_last_ts[ch]) begin
			ring_overwrite_newest(ch, req.volt, req.curr);
		end else begin
			len = (slot_len_ms == 0) ? 1 : 32'(slot_len_ms);
			slots = (req.ts - ring_last_ts[ch]) / len;
			if (slots == 0) begin
				ring_overwrite_newest(ch, req.volt, req.curr);
			end else begin
				if (slots > DEPTH)
					slots = DEPTH;
				p = (ring_wr_pos[ch] + DEPTH - 1) % DEPTH;
				hold_v = volt_ring[ch][p];
				hold_c = curr_ring[ch][p];
				// gap slots repeat the held newest point
				for (int unsigned i = 1; i < slots; i++)
					ring_push(ch, hold_v, hold_c);
				ring_push(ch, req.volt, req.curr);
			end
			ring_last_ts[ch] = req.ts;
		end
	endfunction

	task automatic push_sample(input int unsigned ch, input logic [SAMPLE_W-1:0] v,
			input logic [SAMPLE_W-1:0] c, input logic [TS_W-1:0] ts);
		ring_req_t req;
		req.func = FUNC_RECORD;
		req.ch = CHAN_W'(ch);
		req.volt = v;
		req.curr = c;
		req.ts = ts;
		pending_reqs.push_back(req);
	endtask

	task automatic push_read(input int unsigned ch);
		ring_req_t req;
		req.func = FUNC_READ;
		req.ch = CHAN_W'(ch);
		req.volt = SAMPLE_W'($urandom());
		req.curr = SAMPLE_W'($urandom());
		req.ts = $urandom();
		pending_reqs.push_back(req);
	endtask

	// mostly well-formed time steps per channel, with some noise; a quarter of the items are reads
	task automatic push_random(input logic [SLOT_W-1:0] slot_val);
		int unsigned ch;
		int unsigned eff;
		int unsigned delta;
		int r;
		logic [TS_W-1:0] ts;
		ch = $urandom_range(0, NCH - 1);
		if ($urandom_range(0, 3) == 0) begin
			push_read(ch);
			return;
		end
		eff = (slot_val == 0) ? 1 : 32'(slot_val);
		r = $urandom_range(0, 99);
		if (r < 5) begin
			ts = '0;
		end else if (r < 15) begin
			ts = stim_ts[ch] - $urandom_range(0, 50);
		end else if (r < 35) begin
			ts = stim_ts[ch] + $urandom_range(0, eff - 1);
		end else if (r < 80) begin
			delta = eff * $urandom_range(1, 5) + $urandom_range(0, eff - 1);
			ts = stim_ts[ch] + delta;
		end else if (r < 92) begin
			ts = stim_ts[ch] + eff * $urandom_range(55, 70);
		end else begin
			ts = $urandom();
		end
		if (ts != 0)
			stim_ts[ch] = ts;
		push_sample(ch, SAMPLE_W'($urandom()), SAMPLE_W'($urandom()), ts);
	endtask

	task automatic wait_drained();
		while (!(pending_reqs.size() == 0 && !s_axis_tvalid && expected_points.size() == 0))
			@(posedge clk);
		// a record beat may still be filling gap slots
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic run_phase(input logic [SLOT_W-1:0] slot_val, input int n_items,
			input bit quiet, input bit hold_rx);
		wait_drained();
		cfg_valid <= 1'b1;
		cfg_data <= slot_val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		slot_len_ms = slot_val;
		no_idle = quiet;
		if (hold_rx) begin
			long_hold_req = 1'b1;
			for (int i = 0; i < 3; i++)
				push_read($urandom_range(0, NCH - 1));
		end
		for (int i = 0; i < n_items; i++)
			push_random(slot_val);
	endtask

	// sender: one beat in flight, random gaps between beats unless no_idle is set
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				predict_item(cur_req);
			if (!s_axis_tvalid || s_axis_tready) begin
				if (tx_gap > 0) begin
					tx_gap = tx_gap - 1;
					s_axis_tvalid <= 1'b0;
				end else if (pending_reqs.size() > 0) begin
					cur_req = pending_reqs.pop_front();
					beat_bits = '0;
					beat_bits[CH_LSB +: CHAN_W] = cur_req.ch;
					beat_bits[VOLT_LSB +: SAMPLE_W] = cur_req.volt;
					beat_bits[CURR_LSB +: SAMPLE_W] = cur_req.curr;
					beat_bits[TS_LSB +: TS_W] = cur_req.ts;
					s_axis_tdata <= beat_bits;
					s_axis_tuser <= cur_req.func;
					s_axis_tvalid <= 1'b1;
					tx_gap = no_idle ? 0 : draw_gap();
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// receiver back-pressure
	always @(posedge clk) begin
		if (arst_n) begin
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				rx_hold = LONG_HOLD;
				m_axis_tready <= 1'b0;
			end else if (rx_hold > 0) begin
				rx_hold = rx_hold - 1;
				m_axis_tready <= 1'b0;
			end else if (!no_idle && $urandom_range(0, 9) == 0) begin
				rx_hold = draw_gap();
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// output beat checker
	always @(posedge clk) begin
		ring_point_t exp_pt;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_points.size() == 0) begin
				report_mismatch($sformatf("beat %0d with no point expected", beat_no));
			end else begin
				exp_pt = expected_points.pop_front();
				if (m_axis_tdata[SAMPLE_W-1:0] !== exp_pt.volt)
					report_mismatch($sformatf("beat %0d volt %h, want %h", beat_no,
						m_axis_tdata[SAMPLE_W-1:0], exp_pt.volt));
				if (m_axis_tdata[SAMPLE_W +: SAMPLE_W] !== exp_pt.curr)
					report_mismatch($sformatf("beat %0d curr %h, want %h", beat_no,
						m_axis_tdata[SAMPLE_W +: SAMPLE_W], exp_pt.curr));
				if (m_axis_tuser !== exp_pt.valid)
					report_mismatch($sformatf("beat %0d valid %b, want %b", beat_no,
						m_axis_tuser, exp_pt.valid));
				if (m_axis_tlast !== exp_pt.is_last)
					report_mismatch($sformatf("beat %0d last %b, want %b", beat_no,
						m_axis_tlast, exp_pt.is_last));
			end
			beat_no++;
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("[time_slotted_history_ring_top] ERROR");
			$finish;
		end
	end

	initial begin
		for (int i = 0; i < NCH; i++) begin
			ring_wr_pos[i] = 0;
			ring_fill[i] = 0;
			ring_last_ts[i] = '0;
			stim_ts[i] = 32'd20000 * (i + 1);
			for (int j = 0; j < DEPTH; j++) begin
				volt_ring[i][j] = '0;
				curr_ring[i][j] = '0;
			end
		end
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// directed, slot length at its reset value
		push_read(0);
		push_sample(0, 16'h7FFF, 16'h8000, 32'd0);           // unknown time
		push_sample(0, 16'h8000, 16'h7FFF, 32'd1000);        // last time still unset
		push_sample(0, 16'hFFFF, 16'h0000, 32'd1000);        // not newer
		push_sample(0, 16'h1234, 16'hABCD, 32'd1150);        // inside one slot
		push_sample(0, 16'h0001, 16'hFFFE, 32'd1750);        // three slots
		push_read(0);
		push_sample(0, 16'h5555, 16'hAAAA, 32'hFFFF_FFFF);   // clamped gap fills the ring
		push_sample(0, 16'hAAAA, 16'h5555, 32'd100);         // not newer on a full ring
		push_read(0);
		push_sample(0, 16'h0F0F, 16'hF0F0, 32'hFFFF_FFFF);
		push_sample(0, 16'h3C3C, 16'hC3C3, 32'd1);           // not newer, overwrites the newest point of a full ring
		push_read(0);
		push_sample(1, 16'h0000, 16'h0000, 32'd500);         // empty ring
		push_sample(1, 16'h0102, 16'h0304, 32'd700);         // exactly one slot
		push_sample(1, 16'h0506, 16'h0708, 32'd12900);       // more slots than the ring
		push_sample(1, 16'hFEDC, 16'hBA98, 32'd0);
		push_sample(1, 16'h7654, 16'h3210, 32'd5);           // last time was zero
		push_read(1);
		push_sample(2, 16'h8001, 16'h7FFE, 32'd4000);
		push_sample(2, 16'h4000, 16'hC000, 32'd4400);
		push_sample(3, 16'h0000, 16'hFFFF, 32'hFFFF_FFFE);
		push_read(2);
		push_read(3);

		run_phase(16'd1, 15, 1'b0, 1'b0);
		run_phase(16'd0, 15, 1'b0, 1'b1);
		run_phase(16'hFFFF, 15, 1'b1, 1'b0);
		run_phase(SLOT_W'($urandom_range(2, 1000)), 15, 1'b0, 1'b0);
		run_phase(SLOT_LEN_RST, 15, 1'b0, 1'b0);
		wait_drained();

		if (mismatch_count == 0 && expected_points.size() == 0)
			$display("[time_slotted_history_ring_top] OK");
		else
			$display("[time_slotted_history_ring_top] ERROR");
		$finish;
	end

endmodule
